// ----- rtl/swfs_pkg.sv -----
// package: codes, types and constants of the stop-and-wait frame sender
`timescale 1ns / 1ps

package swfs_pkg;

  localparam logic [7:0] FlagByte  = 8'h7E;
  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] AddrByte  = 8'h03;
  localparam logic [7:0] SeqCtrl   = 8'h40;
  localparam logic [7:0] BaseXor   = 8'h80;
  localparam logic [7:0] AckBits   = 8'h05;
  localparam logic [7:0] RejBits   = 8'h01;
  localparam logic [7:0] RetryRst  = 8'd3;
  localparam logic [7:0] TallyMax  = 8'hFF;

  localparam logic [7:0] TypeData  = 8'h01;
  localparam logic [7:0] TypeCtlA  = 8'h02;
  localparam logic [7:0] TypeCtlB  = 8'h03;

  // a data frame start with last set is longest: flag, 4 header bytes, check, flag
  localparam int MaxEntries = 7;
  localparam int CntW       = $clog2(MaxEntries);

  typedef enum logic [1:0] {
    CMD_PAYLOAD  = 2'd0,
    CMD_RESPONSE = 2'd1,
    CMD_TIMEOUT  = 2'd2,
    CMD_RESERVED = 2'd3
  } command_t;

  typedef enum logic [3:0] {
    ST_BYTE         = 4'd0,
    ST_ACKED        = 4'd1,
    ST_OTHER        = 4'd2,
    ST_REJ_RESEND   = 4'd3,
    ST_TMO_RESEND   = 4'd4,
    ST_TMO_FAIL     = 4'd5,
    ST_REJ_FAIL     = 4'd6,
    ST_IGNORED      = 4'd7,
    ST_BAD_TYPE     = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FRAME   = 2'd1,
    PH_WAIT    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // one buffered result; esc marks a byte between the flags
  typedef struct packed {
    logic [7:0] line_byte;
    logic       has_byte;
    status_t    status;
    logic       esc;
  } entry_t;

  typedef struct packed {
    entry_t [MaxEntries-1:0] ent;
    logic [CntW-1:0]         last_idx;
  } load_t;

endpackage

// ----- rtl/swfs_if.sv -----
// channel interfaces: request input and result output
`timescale 1ns / 1ps

interface swfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data;
  logic       last;

  modport source (output valid, command, data, last, input ready);
  modport sink (input valid, command, data, last, output ready);
endinterface

interface swfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_run;
  logic [3:0] status;

  modport source (output valid, out_byte, has_byte, end_of_run, status, input ready);
  modport sink (input valid, out_byte, has_byte, end_of_run, status, output ready);
endinterface

// ----- rtl/swfs_in_reg.sv -----
// input register stage holding one request
`timescale 1ns / 1ps

module swfs_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  swfs_in_if.sink            in_ch,
  input  logic               take,
  output logic               item_valid,
  output swfs_pkg::in_item_t item
);
  import swfs_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ch.ready = !valid_r || take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{command: in_ch.command, data: in_ch.data, last: in_ch.last};
    end
  end

endmodule

// ----- rtl/swfs_builder.sv -----
// protocol state and result list for one request
`timescale 1ns / 1ps

module swfs_builder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               fire,
  input  swfs_pkg::in_item_t item,
  output swfs_pkg::load_t    load
);
  import swfs_pkg::*;

  logic       seq_r, seq_nxt;
  phase_t     phase_r, phase_nxt;
  logic       df_r, df_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] tt_r, tt_nxt;
  logic [7:0] rj_r, rj_nxt;
  logic [7:0] retries_r;

  logic [7:0] ctrl, base, acc_new, tt_inc, rj_inc;
  logic       good_type, is_cmd_payload, is_cmd_resp, is_cmd_tmo;
  logic       is_ack, is_rej;

  function automatic entry_t mk(logic [7:0] b, logic h, status_t s, logic e);
    entry_t r;
    r.line_byte = b;
    r.has_byte  = h;
    r.status    = s;
    r.esc       = e;
    return r;
  endfunction

  assign ctrl           = seq_r ? SeqCtrl : 8'h00;
  assign base           = {ctrl[6:0], 1'b0} ^ BaseXor;
  assign acc_new        = acc_r ^ item.data;
  assign tt_inc         = (tt_r == TallyMax) ? tt_r : tt_r + 8'd1;
  assign rj_inc         = (rj_r == TallyMax) ? rj_r : rj_r + 8'd1;
  assign good_type      = (item.data == TypeData) || (item.data == TypeCtlA) ||
                          (item.data == TypeCtlB);
  assign is_cmd_payload = (item.command == CMD_PAYLOAD);
  assign is_cmd_resp    = (item.command == CMD_RESPONSE);
  assign is_cmd_tmo     = (item.command == CMD_TIMEOUT);
  assign is_ack         = (item.data == (base | AckBits));
  assign is_rej         = (item.data == (base | RejBits));

  // next state
  always_comb begin
    seq_nxt   = seq_r;
    phase_nxt = phase_r;
    df_nxt    = df_r;
    acc_nxt   = acc_r;
    tt_nxt    = tt_r;
    rj_nxt    = rj_r;
    if (is_cmd_payload && phase_r == PH_IDLE) begin
      if (good_type) begin
        df_nxt    = (item.data == TypeData);
        acc_nxt   = item.data;
        phase_nxt = item.last ? PH_WAIT : PH_FRAME;
      end else begin
        phase_nxt = item.last ? PH_IDLE : PH_DISCARD;
      end
    end else if (is_cmd_payload && phase_r == PH_FRAME) begin
      acc_nxt = acc_new;
      if (item.last) phase_nxt = PH_WAIT;
    end else if (is_cmd_payload && phase_r == PH_DISCARD) begin
      if (item.last) phase_nxt = PH_IDLE;
    end else if ((is_cmd_resp || is_cmd_tmo) && phase_r == PH_WAIT) begin
      phase_nxt = PH_IDLE;
      if (is_cmd_resp && !is_rej) begin
        seq_nxt = !seq_r;
        tt_nxt  = '0;
        rj_nxt  = '0;
      end else begin
        if (is_cmd_tmo) tt_nxt = tt_inc;
        else            rj_nxt = rj_inc;
        if (tt_nxt >= retries_r || rj_nxt >= retries_r) begin
          tt_nxt = '0;
          rj_nxt = '0;
        end
      end
    end
  end

  // result list
  always_comb begin
    load.ent      = '{default: mk(8'h00, 1'b0, ST_IGNORED, 1'b0)};
    load.last_idx = '0;
    if (is_cmd_payload && phase_r == PH_IDLE) begin
      if (good_type) begin
        load.ent[0]   = mk(FlagByte, 1'b1, ST_BYTE, 1'b0);
        load.ent[1]   = mk(AddrByte, 1'b1, ST_BYTE, 1'b1);
        load.ent[2]   = mk(ctrl, 1'b1, ST_BYTE, 1'b1);
        load.ent[3]   = mk(AddrByte ^ ctrl, 1'b1, ST_BYTE, 1'b1);
        load.ent[4]   = mk(item.data, 1'b1, ST_BYTE, 1'b1);
        load.last_idx = CntW'(4);
        if (item.last) begin
          if (item.data == TypeData) begin
            load.ent[5]   = mk(item.data, 1'b1, ST_BYTE, 1'b1);
            load.ent[6]   = mk(FlagByte, 1'b1, ST_BYTE, 1'b0);
            load.last_idx = CntW'(6);
          end else begin
            load.ent[5]   = mk(FlagByte, 1'b1, ST_BYTE, 1'b0);
            load.last_idx = CntW'(5);
          end
        end
      end else begin
        load.ent[0] = mk(8'h00, 1'b0, ST_BAD_TYPE, 1'b0);
      end
    end else if (is_cmd_payload && phase_r == PH_FRAME) begin
      load.ent[0] = mk(item.data, 1'b1, ST_BYTE, 1'b1);
      if (item.last) begin
        if (df_r) begin
          load.ent[1]   = mk(acc_new, 1'b1, ST_BYTE, 1'b1);
          load.ent[2]   = mk(FlagByte, 1'b1, ST_BYTE, 1'b0);
          load.last_idx = CntW'(2);
        end else begin
          load.ent[1]   = mk(FlagByte, 1'b1, ST_BYTE, 1'b0);
          load.last_idx = CntW'(1);
        end
      end
    end else if (is_cmd_resp && phase_r == PH_WAIT) begin
      priority if (is_ack) begin
        load.ent[0] = mk(8'h00, 1'b0, ST_ACKED, 1'b0);
      end else if (is_rej) begin
        priority if (tt_r >= retries_r)   load.ent[0] = mk(8'h00, 1'b0, ST_TMO_FAIL, 1'b0);
        else if (rj_inc >= retries_r)     load.ent[0] = mk(8'h00, 1'b0, ST_REJ_FAIL, 1'b0);
        else                              load.ent[0] = mk(8'h00, 1'b0, ST_REJ_RESEND, 1'b0);
      end else begin
        load.ent[0] = mk(8'h00, 1'b0, ST_OTHER, 1'b0);
      end
    end else if (is_cmd_tmo && phase_r == PH_WAIT) begin
      priority if (tt_inc >= retries_r)  load.ent[0] = mk(8'h00, 1'b0, ST_TMO_FAIL, 1'b0);
      else if (rj_r >= retries_r)        load.ent[0] = mk(8'h00, 1'b0, ST_REJ_FAIL, 1'b0);
      else                               load.ent[0] = mk(8'h00, 1'b0, ST_TMO_RESEND, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retries_r <= RetryRst;
    end else if (cfg_we) begin
      retries_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= 1'b1;
      phase_r <= PH_IDLE;
      df_r    <= 1'b0;
      acc_r   <= '0;
      tt_r    <= '0;
      rj_r    <= '0;
    end else if (fire) begin
      seq_r   <= seq_nxt;
      phase_r <= phase_nxt;
      df_r    <= df_nxt;
      acc_r   <= acc_nxt;
      tt_r    <= tt_nxt;
      rj_r    <= rj_nxt;
    end
  end

endmodule

// ----- rtl/swfs_out_seq.sv -----
// result buffer and byte escaper on the output channel
`timescale 1ns / 1ps

module swfs_out_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  swfs_pkg::load_t load,
  output logic            free,
  swfs_out_if.source      out_ch
);
  import swfs_pkg::*;

  entry_t          entries_r [MaxEntries];
  logic [CntW-1:0] last_idx_r;
  logic [CntW-1:0] idx_r;
  logic            busy_r;
  logic            half_r;

  entry_t cur;
  logic   needs_esc, first_half, fin, beat;

  assign cur        = entries_r[idx_r];
  assign needs_esc  = cur.esc && (cur.line_byte == FlagByte || cur.line_byte == EscByte);
  assign first_half = needs_esc && !half_r;
  assign fin        = (idx_r == last_idx_r) && !first_half;
  assign beat       = out_ch.valid && out_ch.ready;
  assign free       = !busy_r || (beat && fin);

  assign out_ch.valid      = busy_r;
  assign out_ch.out_byte   = first_half ? EscByte :
                             (needs_esc ? (cur.line_byte ^ EscXor) : cur.line_byte);
  assign out_ch.has_byte   = cur.has_byte;
  assign out_ch.end_of_run = fin;
  assign out_ch.status     = cur.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      half_r <= 1'b0;
      idx_r  <= '0;
    end else if (free) begin
      busy_r <= item_valid;
      half_r <= 1'b0;
      idx_r  <= '0;
    end else if (beat) begin
      if (first_half) begin
        half_r <= 1'b1;
      end else begin
        half_r <= 1'b0;
        idx_r  <= idx_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free && item_valid) begin
      for (int i = 0; i < MaxEntries; i++) begin
        entries_r[i] <= load.ent[i];
      end
      last_idx_r <= load.last_idx;
    end
  end

endmodule

// ----- rtl/stop_and_wait_frame_sender_core.sv -----
// top level of the stop-and-wait frame sender
//
//   channel   dir  handshake            contents
//   in_ch     in   valid/ready          command, data, last
//   out_ch    out  valid/ready          out_byte, has_byte, end_of_run, status
//   cfg       in   cfg_we, no stall     cfg_wdata -> max_retries
//
// a request waits in the input register; output beats leave one per cycle unless stalled
// a request's result list holds 1 entry for a response or timeout,
// up to 7 for a one-byte data frame (flag, four header bytes, check, flag);
// an escaped payload or check byte takes two beats of the escaper
// the next request is taken in the cycle the last beat of the previous one is taken
// synchronous active-low reset: seq set, phase and tallies cleared, retry limit to 3
// a stalled output holds its beat and backs up into the input register
`timescale 1ns / 1ps

module stop_and_wait_frame_sender_core (
  input  logic       clk,
  input  logic       rst_n,
  swfs_in_if.sink    in_ch,
  swfs_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import swfs_pkg::*;

  // request held in the input register
  logic     item_valid;
  in_item_t item;
  // output buffer can take a new result list
  logic     free;
  load_t    load;

  swfs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (free),
    .item_valid (item_valid),
    .item       (item)
  );

  // framing and retry state advance when a request moves into the buffer
  swfs_builder u_builder (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (item_valid && free),
    .item      (item),
    .load      (load)
  );

  // result list drained beat by beat, escape bytes inserted on the fly
  swfs_out_seq u_out_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .load       (load),
    .free       (free),
    .out_ch     (out_ch)
  );

endmodule
